// ----- design/dedup_set_table_top_assert.svh -----
// Assertion macros for the dedup set table checker.
`ifndef DEDUP_SET_TABLE_TOP_ASSERT_SVH
`define DEDUP_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define DST_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define DST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dst_pkg.sv -----
// Shared constants and types for the dedup set table.
package dst_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int ECNT_W  = 5;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BADIDX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RDWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [ECNT_W-1:0] entry_count;
        logic              is_empty;
        status_t           status;
    } res_t;

endpackage

// ----- design/dst_ram.sv -----
// Generic simple dual-port RAM with registered read.
module dst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dst_engine.sv -----
// Sequencer: duplicate scan, shift-down remove and indexed read over the entry RAM.
module dst_engine import dst_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    input  logic [DATA_W-1:0]  in_value,
    input  logic [IDX_W-1:0]   in_index,
    input  logic               slot_free,
    output logic               res_valid,
    output res_t               res,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [STORE_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [STORE_W-1:0] ram_rdata
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [STORE_W-1:0] val_reg, val_next;
    logic [STORE_W-1:0] rd_reg, rd_next;
    status_t            stat_reg, stat_next;

    logic [STORE_W-1:0] v_in;
    logic [CNT_W-1:0]   idx_c;
    logic               idx_ok;
    logic               idx_last;
    logic               is_full;
    logic               scan_hit;
    logic               scan_end;
    logic               shift_last;

    assign v_in       = STORE_W'(in_value);
    assign idx_c      = CNT_W'(in_index);
    assign idx_ok     = CMP_W'(in_index) < CMP_W'(count_reg);
    assign idx_last   = idx_c == (count_reg - CNT_W'(1));
    assign is_full    = count_reg == CNT_W'(CAPACITY);
    assign scan_hit   = ram_rdata == val_reg;
    assign scan_end   = ptr_reg == count_reg;
    assign shift_last = ptr_reg == (count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        val_reg  <= val_next;
        rd_reg   <= rd_next;
        stat_reg <= stat_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        val_next   = val_reg;
        rd_next    = rd_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = v_in;
                    rd_next    = '0;
                    stat_next  = STAT_OK;
                    state_next = S_DONE;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (count_reg == '0)
                            begin
                                count_next = CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                stat_next = STAT_BADIDX;
                            end
                            else if (idx_last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = idx_c + CNT_W'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                stat_next = STAT_BADIDX;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_BADIDX;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    stat_next  = STAT_DUP;
                    state_next = S_DONE;
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                    if (is_full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_RDWAIT:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and RAM control
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_ADD:
                        begin
                            if (count_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = v_in;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_ok && !idx_last)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(idx_c + CNT_W'(1));
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(in_index);
                            end
                        end
                        default:
                        begin
                            ram_re = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!scan_hit && scan_end && !is_full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(count_reg);
                    ram_wdata = val_reg;
                end
                else if (!scan_hit && !scan_end)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(ptr_reg);
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(ptr_reg - CNT_W'(1));
                ram_wdata = ram_rdata;
                if (!shift_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(ptr_reg + CNT_W'(1));
                end
            end
            S_DONE:
            begin
                res_valid = slot_free;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res.read_value  = DATA_W'(rd_reg);
    assign res.entry_count = ECNT_W'(count_reg);
    assign res.is_empty    = count_reg == '0;
    assign res.status      = stat_reg;

endmodule

// ----- design/dedup_set_table_top.sv -----
// Top level of the dedup set table: entry RAM, sequencer and result register.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_*     | in  | value[31:0], index[35:32], zero pad             | opcode[1:0]
//  m_*     | out | read_value[31:0], entry_count[36:32],            | -
//          |     | is_empty[37], status[39:38]                      |
//
// Transactions are all bound by the single RAM read port: add scans the stored
// entries for a duplicate and stops at a match; remove shifts the entries above
// the index down; read waits on the registered RAM read.
// Reset clears the count, sequencer state and output valid only; entries are never read before written, no sweep.
// A result waits in the output register; the next transaction is taken meanwhile,
// and the sequencer holds its finished result only while that register stays full.
module dedup_set_table_top import dst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], index[35:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_value, entry_count, is_empty, status
);

    logic               slot_free;
    logic               res_valid;
    res_t               res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [STORE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [STORE_W-1:0] ram_rdata;

    logic               m_valid_reg, m_valid_next;
    res_t               m_res_reg;

    dst_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata[31:0]),
        .in_index  (s_tdata[35:32]),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dst_ram #(
        .WIDTH (STORE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.status, m_res_reg.is_empty,
                       m_res_reg.entry_count, m_res_reg.read_value};

endmodule

// ----- design/dst_checker.sv -----
// Port-level assertion checker for the dedup set table, bound to the top level.
`include "dedup_set_table_top_assert.svh"

module dst_checker import dst_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `DST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `DST_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `DST_ASSERT_IMPLY(a_count_max, m_tvalid, m_tdata[36:32] <= ECNT_W'(CAPACITY), "count over capacity")
    `DST_ASSERT_IMPLY(a_empty_flag, m_tvalid, m_tdata[37] == (m_tdata[36:32] == '0), "empty flag mismatch")
    `DST_ASSERT_IMPLY(a_err_zero, m_tvalid && (m_tdata[39:38] != STAT_OK), m_tdata[31:0] == '0, "nonzero data on error")

endmodule

bind dedup_set_table_top dst_checker u_dst_checker (.*);
